// File: design/swr_pkg.sv
`default_nettype none

package swr_pkg;

  // Result codes on the status port
  typedef enum logic [2:0] {
    ST_ACCEPT  = 3'd0,
    ST_BADSUM  = 3'd1,
    ST_AHEAD   = 3'd2,
    ST_DUP     = 3'd3,
    ST_DONE    = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  // What the front hands to the back for one finished beat
  typedef enum logic [1:0] {
    EV_PACKET  = 2'd0,
    EV_END     = 2'd1,
    EV_IGNORED = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] seq_no;
    logic        sum_good;   // checksum matched and length within limit
  } event_t;

  // Event queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int unsigned SUM_W = 16;

endpackage

`default_nettype wire

// File: design/stop_and_wait_receiver.sv
`default_nettype none

// Channel   Handshake          Beat
// input     push / full        seq_no, hdr_checksum, pkt_len, data_byte, last_byte
// result    empty / pop        status, send_ack, ack_no
//
// One input beat per cycle while full is low; the front sums each byte in
// the cycle it arrives. After its last beat a result is written to the
// event queue, then passes the sequence check in the back stage into the
// output register; results queued behind a stalled pop wait in the queue.
// Reset clears the running sum, end-of-transfer flag, last accepted sequence
// and the event queue. full rises only when the four-entry event queue fills
// while results are not being popped.

module stop_and_wait_receiver
  import swr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] seq_no,
  input  wire logic [15:0] hdr_checksum,
  input  wire logic [10:0] pkt_len,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       status,
  output logic             send_ack,
  output logic [31:0]      ack_no
);

  logic   in_beat;
  logic   ev_push;
  event_t ev_data;
  logic   ev_valid;
  event_t ev_head;
  logic   ev_pop;

  assign in_beat = push && !full;

  swr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .beat         (in_beat),
    .seq_no       (seq_no),
    .hdr_checksum (hdr_checksum),
    .pkt_len      (pkt_len),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .ev_push      (ev_push),
    .ev_data      (ev_data)
  );

  swr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_data (ev_data),
    .pop       (ev_pop),
    .full      (full),
    .valid     (ev_valid),
    .head      (ev_head)
  );

  swr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev_valid),
    .ev_head  (ev_head),
    .ev_pop   (ev_pop),
    .pop      (pop),
    .empty    (empty),
    .status   (status),
    .send_ack (send_ack),
    .ack_no   (ack_no)
  );

endmodule

`default_nettype wire

// File: design/swr_front.sv
`default_nettype none

module swr_front
  import swr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        beat,          // input beat accepted this cycle
  input  wire logic [31:0] seq_no,
  input  wire logic [15:0] hdr_checksum,
  input  wire logic [10:0] pkt_len,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             ev_push,
  output event_t           ev_data
);

  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  logic             transfer_done;
  logic             transfer_done_next;

  logic [SUM_W:0]   raw_sum;
  logic [SUM_W-1:0] folded_sum;
  logic             len_ok;

  // One add, then fold the end-around carry (one fold always suffices)
  assign raw_sum    = {1'b0, running_sum} + {{(SUM_W-7){1'b0}}, data_byte};
  assign folded_sum = raw_sum[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, raw_sum[SUM_W]};
  assign len_ok     = (32'(pkt_len) <= 32'(MAX_PAYLOAD));

  // Classify the beat and update the sum
  always_comb begin
    running_sum_next   = running_sum;
    transfer_done_next = transfer_done;
    ev_push            = 1'b0;
    ev_data.kind       = EV_PACKET;
    ev_data.seq_no     = seq_no;
    ev_data.sum_good   = len_ok && ((~folded_sum) == hdr_checksum);
    if (beat) begin
      if (transfer_done) begin
        ev_push      = 1'b1;
        ev_data.kind = EV_IGNORED;
      end else if (pkt_len == '0) begin
        ev_push            = 1'b1;
        ev_data.kind       = EV_END;
        transfer_done_next = 1'b1;
        running_sum_next   = '0;
      end else if (last_byte) begin
        ev_push          = 1'b1;
        running_sum_next = '0;
      end else begin
        running_sum_next = folded_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      transfer_done <= 1'b0;
    end else begin
      running_sum   <= running_sum_next;
      transfer_done <= transfer_done_next;
    end
  end

endmodule

`default_nettype wire

// File: design/swr_queue.sv
`default_nettype none

module swr_queue
  import swr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  event_t      push_data,
  input  wire logic   pop,
  output logic        full,
  output logic        valid,
  output event_t      head
);

  event_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/swr_back.sv
`default_nettype none

module swr_back
  import swr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        ev_valid,
  input  event_t           ev_head,
  output logic             ev_pop,
  input  wire logic        pop,
  output logic             empty,
  output logic [2:0]       status,
  output logic             send_ack,
  output logic [31:0]      ack_no
);

  logic [31:0] last_accepted_seq;
  logic [31:0] expected;
  logic        out_valid;
  status_t     status_next;
  logic [31:0] ack_no_next;
  logic        send_ack_next;

  // Take an event when the output register is free or being drained
  assign ev_pop   = ev_valid && (!out_valid || pop);
  assign expected = last_accepted_seq + 32'd1;
  assign empty    = !out_valid;

  // Sequence check first, checksum only for an in-order packet
  always_comb begin
    status_next   = ST_IGNORED;
    send_ack_next = 1'b0;
    ack_no_next   = '0;
    case (ev_head.kind)
      EV_END: begin
        status_next = ST_DONE;
      end
      EV_PACKET: begin
        if (ev_head.seq_no == expected) begin
          if (ev_head.sum_good) begin
            status_next   = ST_ACCEPT;
            send_ack_next = 1'b1;
            ack_no_next   = ev_head.seq_no + 32'd1;
          end else begin
            status_next = ST_BADSUM;
          end
        end else if (ev_head.seq_no > expected) begin
          status_next = ST_AHEAD;
        end else begin
          status_next = ST_DUP;
        end
      end
      default: begin
        status_next = ST_IGNORED;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      last_accepted_seq <= '0;
    end else begin
      if (ev_pop) begin
        out_valid <= 1'b1;
        if (status_next == ST_ACCEPT) begin
          last_accepted_seq <= ev_head.seq_no;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ev_pop) begin
      status   <= status_next;
      send_ack <= send_ack_next;
      ack_no   <= ack_no_next;
    end
  end

endmodule

`default_nettype wire

// File: test/swr_checker.sv
`default_nettype none

module swr_checker
  import swr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [31:0] seq_no,
  input  wire logic [15:0] hdr_checksum,
  input  wire logic [10:0] pkt_len,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [2:0]  status,
  input  wire logic        send_ack,
  input  wire logic [31:0] ack_no,
  output int unsigned      errors,
  output int unsigned      pending
);

  typedef struct packed {
    status_t     st;
    logic        ack;
    logic [31:0] ackno;
  } ack_verdict_t;

  ack_verdict_t verdict_q[$];

  // Receiver state as seen from outside
  logic [31:0] last_ok;
  logic [17:0] ones_sum;
  logic        xfer_done;

  // Ones' complement add with end-around carry
  function automatic logic [17:0] add_byte(input logic [17:0] s, input logic [7:0] b);
    logic [17:0] t;
    t = s + {10'd0, b};
    t = {2'b00, t[15:0]} + {16'd0, t[17:16]};
    t = {2'b00, t[15:0]} + {16'd0, t[17:16]};
    return t;
  endfunction

  // Predict the verdict for one accepted input beat
  task automatic classify_beat();
    ack_verdict_t v;
    logic [15:0]  cks;
    logic [31:0]  next_seq;
    v = '{st: ST_IGNORED, ack: 1'b0, ackno: 32'd0};
    if (xfer_done) begin
      verdict_q.push_back(v);
    end else if (pkt_len == 11'd0) begin
      xfer_done = 1'b1;
      ones_sum  = '0;
      v.st      = ST_DONE;
      verdict_q.push_back(v);
    end else begin
      ones_sum = add_byte(ones_sum, data_byte);
      if (last_byte) begin
        cks      = ~ones_sum[15:0];
        ones_sum = '0;
        next_seq = last_ok + 32'd1;
        if (seq_no == next_seq) begin
          if (pkt_len <= MAX_PAYLOAD && cks == hdr_checksum) begin
            last_ok = seq_no;
            v.st    = ST_ACCEPT;
            v.ack   = 1'b1;
            v.ackno = seq_no + 32'd1;
          end else begin
            v.st = ST_BADSUM;
          end
        end else if (seq_no > next_seq) begin
          v.st = ST_AHEAD;
        end else begin
          v.st = ST_DUP;
        end
        verdict_q.push_back(v);
      end
    end
  endtask

  // Compare each popped result with the oldest prediction
  always @(posedge clk) begin
    ack_verdict_t w;
    if (rst) begin
      verdict_q.delete();
      last_ok   = '0;
      ones_sum  = '0;
      xfer_done = 1'b0;
      errors    <= 0;
    end else begin
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result beat: status %0d send_ack %0d ack_no %h",
                     status, send_ack, ack_no);
          errors <= errors + 1;
        end else begin
          w = verdict_q.pop_front();
          if (status !== w.st || send_ack !== w.ack || ack_no !== w.ackno) begin
            if (errors < 10)
              $display("mismatch: status %0d/%0d send_ack %0d/%0d ack_no %h/%h (exp/got)",
                       w.st, status, w.ack, send_ack, w.ackno, ack_no);
            errors <= errors + 1;
          end
        end
      end
      if (push && !full)
        classify_beat();
    end
    pending <= verdict_q.size();
  end

endmodule

`default_nettype wire

// File: test/tb_stop_and_wait_receiver.sv
`default_nettype none

module tb_stop_and_wait_receiver;

  localparam int unsigned MAXP       = 1024;
  localparam int unsigned QUIET_MAX  = 3000;
  localparam int unsigned ITEM_GOAL  = 1250;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [31:0] seq_no;
  logic [15:0] hdr_checksum;
  logic [10:0] pkt_len;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        empty;
  logic        pop;
  logic [2:0]  status;
  logic        send_ack;
  logic [31:0] ack_no;

  int unsigned errors;
  int unsigned pending;

  // Stimulus bookkeeping
  int unsigned nitems;
  logic [31:0] last_ok;
  bit          send_gaps;
  bit          pop_stalls;

  stop_and_wait_receiver #(.MAX_PAYLOAD(MAXP)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .seq_no(seq_no), .hdr_checksum(hdr_checksum), .pkt_len(pkt_len),
    .data_byte(data_byte), .last_byte(last_byte),
    .empty(empty), .pop(pop), .status(status), .send_ack(send_ack), .ack_no(ack_no)
  );

  swr_checker #(.MAX_PAYLOAD(MAXP)) chk (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .seq_no(seq_no), .hdr_checksum(hdr_checksum), .pkt_len(pkt_len),
    .data_byte(data_byte), .last_byte(last_byte),
    .empty(empty), .pop(pop), .status(status), .send_ack(send_ack), .ack_no(ack_no),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Checksum the sender puts in the header
  function automatic logic [15:0] packet_checksum(input logic [7:0] body[$]);
    logic [17:0] s;
    s = '0;
    foreach (body[i]) begin
      s = s + {10'd0, body[i]};
      s = {2'b00, s[15:0]} + {16'd0, s[17:16]};
    end
    return ~s[15:0];
  endfunction

  // One input beat, held until accepted
  task automatic send_beat(input logic [31:0] s, input logic [15:0] c, input logic [10:0] l,
                           input logic [7:0] b, input logic lb);
    int g;
    if (send_gaps && $urandom_range(0, 99) < 20) begin
      g = gap_len();
      repeat (g) begin
        @(negedge clk);
        push <= 1'b0;
      end
    end
    @(negedge clk);
    push         <= 1'b1;
    seq_no       <= s;
    hdr_checksum <= c;
    pkt_len      <= l;
    data_byte    <= b;
    last_byte    <= lb;
    do @(posedge clk); while (full);
    nitems++;
  endtask

  // A whole packet of n bytes; tracks what the receiver will accept
  task automatic send_packet(input logic [31:0] s, input int n, input logic [10:0] l,
                             input bit good);
    logic [7:0]  body[$];
    logic [15:0] c;
    for (int i = 0; i < n; i++)
      body.push_back(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
    c = packet_checksum(body);
    if (!good)
      c = c ^ 16'($urandom_range(1, 65535));
    for (int i = 0; i < n; i++)
      send_beat(s, c, l, body[i], i == n - 1);
    if (s == last_ok + 32'd1 && good && l <= MAXP)
      last_ok = s;
  endtask

  // Hold the sender until every expected result is out
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: pop with random stalls
  initial begin
    int stall;
    stall = 0;
    pop   = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (pop_stalls && $urandom_range(0, 99) < 15)
          stall = gap_len();
      end
    end
  end

  // Watchdog: no beat on either side for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Main stimulus
  initial begin
    int          n;
    int          r;
    int unsigned mode_at;
    bit          paused;
    logic [31:0] s;
    logic [10:0] l;
    rst          = 1'b1;
    push         = 1'b0;
    seq_no       = '0;
    hdr_checksum = '0;
    pkt_len      = '0;
    data_byte    = '0;
    last_byte    = 1'b0;
    nitems       = 0;
    last_ok      = '0;
    send_gaps    = 1'b0;
    pop_stalls   = 1'b0;
    paused       = 1'b0;
    mode_at      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: in order, fold carries, length extremes, oversize, bad sum, dup, ahead
    send_packet(32'd1, 1, 11'd1, 1'b1);
    // 260 bytes of 0xFF: the sum wraps past 16 bits
    repeat (259) send_beat(32'd2, 16'hFD02, 11'd260, 8'hFF, 1'b0);
    send_beat(32'd2, 16'hFD02, 11'd260, 8'hFF, 1'b1);
    last_ok = 32'd2;
    send_packet(32'd3, 2, 11'd1024, 1'b1);
    send_packet(32'd4, 1, 11'd1025, 1'b1);
    send_packet(32'd4, 2, 11'd2, 1'b0);
    send_packet(32'd4, 1, 11'd2047, 1'b1);
    send_packet(32'd0, 1, 11'd1, 1'b1);
    send_packet(32'hFFFF_FFFF, 1, 11'd1, 1'b1);
    send_packet(32'd2, 2, 11'd2, 1'b1);
    send_packet(32'd5, 1, 11'd1, 1'b1);
    send_beat(32'd4, 16'hFF00, 11'd1, 8'hFF, 1'b1);
    last_ok = 32'd4;
    send_packet(32'd5, 3, 11'd3, 1'b1);
    drain();

    // Random: mostly in-order packets, some broken ones
    while (nitems < ITEM_GOAL) begin
      if (nitems >= mode_at) begin
        send_gaps  = $urandom_range(0, 3) != 0;
        pop_stalls = $urandom_range(0, 3) != 0;
        mode_at    = nitems + $urandom_range(80, 200);
      end
      if (!paused && nitems > ITEM_GOAL / 2) begin
        drain();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      if ($urandom_range(0, 199) == 0)
        n = 300;
      l = 11'(n);
      if (r < 70) begin
        s = last_ok + 32'd1;
        r = $urandom_range(0, 99);
        if (r < 85)
          send_packet(s, n, l, 1'b1);
        else if (r < 93)
          send_packet(s, n, l, 1'b0);
        else
          send_packet(s, n, 11'($urandom_range(MAXP + 1, 2047)), 1'b1);
      end else if (r < 85) begin
        s = 32'($urandom_range(0, last_ok));
        send_packet(s, n, 11'($urandom_range(1, 2047)), 1'($urandom_range(0, 1)));
      end else begin
        s = 32'($urandom());
        if (s <= last_ok + 32'd1)
          s = last_ok + 32'd1 + 32'($urandom_range(1, 1000));
        send_packet(s, n, 11'($urandom_range(1, 2047)), 1'($urandom_range(0, 1)));
      end
    end

    // End of transfer mid-packet, then beats that are ignored
    send_beat(last_ok + 32'd1, 16'h1234, 11'd5, 8'($urandom_range(0, 255)), 1'b0);
    send_beat(last_ok + 32'd1, 16'h1234, 11'd5, 8'($urandom_range(0, 255)), 1'b0);
    send_beat(32'($urandom()), 16'($urandom_range(0, 65535)), 11'd0,
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat (20) begin
      l = ($urandom_range(0, 3) == 0) ? 11'd0 : 11'($urandom_range(1, 2047));
      send_beat(last_ok + 32'd1, 16'($urandom_range(0, 65535)), l,
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
design/swr_pkg.sv
design/swr_front.sv
design/swr_queue.sv
design/swr_back.sv
design/stop_and_wait_receiver.sv
test/swr_checker.sv
test/tb_stop_and_wait_receiver.sv
